>>> design/assert_macros.svh
// Assertion macros shared by the design files.
// Plain text, no dependencies; every macro samples on clock and is off in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/clcs_pkg.sv
// Package for the current limit calibration sequencer: types, register
// indexes, reset values and the default per-entry tables. No dependencies.
package clcs_pkg;

   localparam int unsigned TABLE_ROWS = 16;

   typedef logic [2:0] csr_index_type;

   localparam csr_index_type CSR_RAMP_LIMIT    = 3'd0;
   localparam csr_index_type CSR_SETTLE_TICKS  = 3'd1;
   localparam csr_index_type CSR_STABLE_NEEDED = 3'd2;
   localparam csr_index_type CSR_ACCEPT_WINDOW = 3'd3;
   localparam csr_index_type CSR_TUNE_DEADBAND = 3'd4;
   localparam csr_index_type CSR_OUTPUT_MAX    = 3'd5;

   localparam logic [15:0] RESET_RAMP_LIMIT    = 16'd4800;
   localparam logic [7:0]  RESET_SETTLE_TICKS  = 8'd50;
   localparam logic [7:0]  RESET_STABLE_NEEDED = 8'd10;
   localparam logic [11:0] RESET_ACCEPT_WINDOW = 12'd30;
   localparam logic [11:0] RESET_TUNE_DEADBAND = 12'd3;
   localparam logic [15:0] RESET_OUTPUT_MAX    = 16'd2400;

   // evaluation result handed from the tuning datapath to the sequencer
   typedef struct packed {
      logic        in_window;
      logic [15:0] integ;
   } tune_result_type;

   function automatic logic [15:0] default_pwm(input logic [3:0] row);
      logic [15:0] val;
      unique case (row)
         4'd0:    val = 16'd470;
         4'd1:    val = 16'd570;
         4'd2:    val = 16'd660;
         4'd3:    val = 16'd740;
         4'd4:    val = 16'd790;
         4'd5:    val = 16'd900;
         4'd6:    val = 16'd550;
         4'd7:    val = 16'd570;
         4'd8:    val = 16'd660;
         4'd9:    val = 16'd740;
         4'd10:   val = 16'd790;
         4'd11:   val = 16'd900;
         default: val = 16'd0;
      endcase
      return val;
   endfunction

   function automatic logic [8:0] default_target(input logic [3:0] row);
      logic [8:0] val;
      unique case (row)
         4'd0:    val = 9'd135;
         4'd1:    val = 9'd140;
         4'd2:    val = 9'd156;
         4'd3:    val = 9'd171;
         4'd4:    val = 9'd186;
         4'd5:    val = 9'd200;
         4'd6:    val = 9'd250;
         4'd7:    val = 9'd280;
         4'd8:    val = 9'd312;
         4'd9:    val = 9'd342;
         4'd10:   val = 9'd372;
         4'd11:   val = 9'd400;
         default: val = 9'd0;
      endcase
      return val;
   endfunction

endpackage

>>> design/current_limit_calibration_sequencer.sv
// Current limit calibration sequencer, top level.
// Depends on clcs_pkg, clcs_tune and assert_macros.svh.
//
// Usage:
//  - req_ channel: one transfer per millisecond tick, carrying req_current.
//  - rsp_ channel: exactly one result transfer per request transfer, in order.
//    The first ramp_limit ticks ramp the drive level (rsp_motor_valid/level).
//    After that every (settle_ticks+1)-th tick is evaluated against the
//    active entry's target: outside the window the integrator steps and
//    rsp_limit_valid/pwm report it; after more than stable_needed hits in
//    the window the entry is stored (rsp_store_valid/index/value). Storing
//    the last entry raises rsp_finished, which then stays set.
//  - csr_ port: write-only, register index in csr_index, data in csr_wdata;
//    write only while no transfer is in flight.
// Timing: a request transfer's result is registered in the output register
//  in the cycle after the transfer. Throughput: one transfer per cycle while
//  rsp_ready is held high; the whole step is a single pass from the accepted
//  sample and the state registers to the output register and next state.
// Stall: req_ready stays high while the output register is empty or being
//  drained; when the receiver holds rsp_ready low, the held result blocks
//  the request side.
// Reset: clears sequencer state and the output valid bit, but not the result
//  fields; reloads register defaults and restores the default PWM table.
`include "assert_macros.svh"

module current_limit_calibration_sequencer import clcs_pkg::*; #(
   parameter int unsigned ENTRY_COUNT = 12
) (
   input  logic          clock,
   input  logic          reset,
   // request channel
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [11:0]   req_current,
   // result channel
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic          rsp_motor_valid,
   output logic [14:0]   rsp_motor_level,
   output logic          rsp_limit_valid,
   output logic [15:0]   rsp_limit_pwm,
   output logic          rsp_store_valid,
   output logic [3:0]    rsp_store_index,
   output logic [15:0]   rsp_store_value,
   output logic          rsp_finished,
   // configuration
   input  logic          csr_we,
   input  csr_index_type csr_index,
   input  logic [15:0]   csr_wdata
);

   localparam logic [3:0] LAST_ENTRY = 4'(ENTRY_COUNT - 1);
   localparam int unsigned TAB_IW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;

   // configuration registers
   logic [15:0] ramp_limit_ff;
   logic [7:0]  settle_ticks_ff;
   logic [7:0]  stable_needed_ff;
   logic [11:0] accept_window_ff;
   logic [11:0] tune_deadband_ff;
   logic [15:0] output_max_ff;

   // sequencer state
   logic [15:0] ramp_level_ff,  ramp_level_in;
   logic [7:0]  tick_count_ff,  tick_count_in;
   logic [7:0]  stable_hits_ff, stable_hits_in;
   logic [3:0]  entry_index_ff, entry_index_in;
   logic [15:0] integrator_ff,  integrator_in;
   logic [15:0] tuned_pwm_ff,   tuned_pwm_in;
   logic        done_ff,        done_in;
   logic [15:0] pwm_table_ff [ENTRY_COUNT];
   logic        table_we;

   // output register
   logic        rsp_valid_ff,   rsp_valid_in;
   logic        motor_valid_ff, motor_valid_in;
   logic [14:0] motor_level_ff, motor_level_in;
   logic        limit_valid_ff, limit_valid_in;
   logic [15:0] limit_pwm_ff,   limit_pwm_in;
   logic        store_valid_ff, store_valid_in;
   logic [3:0]  store_index_ff, store_index_in;
   logic [15:0] store_value_ff, store_value_in;
   logic        finished_ff,    finished_in;

   logic            req_xfer;
   logic [3:0]      idx;           // active entry, clamped to the table
   logic [3:0]      idx_next;
   logic [15:0]     ramp_inc;
   logic [7:0]      tick_inc;
   logic [7:0]      hits_inc;
   tune_result_type tune;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_xfer  = req_valid && req_ready;

   assign idx      = (entry_index_ff > LAST_ENTRY) ? LAST_ENTRY : entry_index_ff;
   assign idx_next = idx + 4'd1;
   assign ramp_inc = ramp_level_ff + 16'd1;
   assign tick_inc = tick_count_ff + 8'd1;
   assign hits_inc = stable_hits_ff + 8'd1;

   clcs_tune u_tune (
      .current       (req_current),
      .target        (default_target(idx)),
      .integrator    (integrator_ff),
      .accept_window (accept_window_ff),
      .tune_deadband (tune_deadband_ff),
      .output_max    (output_max_ff),
      .result        (tune)
   );

   // one step of the sequence for the sample being transferred
   always_comb begin
      ramp_level_in  = ramp_level_ff;
      tick_count_in  = tick_count_ff;
      stable_hits_in = stable_hits_ff;
      entry_index_in = entry_index_ff;
      integrator_in  = integrator_ff;
      tuned_pwm_in   = tuned_pwm_ff;
      done_in        = done_ff;
      table_we       = 1'b0;

      motor_valid_in = 1'b0;
      motor_level_in = 15'd0;
      limit_valid_in = 1'b0;
      limit_pwm_in   = 16'd0;
      store_valid_in = 1'b0;
      store_index_in = 4'd0;
      store_value_in = 16'd0;
      finished_in    = 1'b0;

      priority if (done_ff) begin
         finished_in = 1'b1;
      end else if (ramp_level_ff < ramp_limit_ff) begin
         ramp_level_in  = ramp_inc;
         tick_count_in  = 8'd0;
         motor_valid_in = 1'b1;
         motor_level_in = ramp_inc[15:1];
      end else if (tick_inc <= settle_ticks_ff) begin
         tick_count_in = tick_inc;   // settling, nothing reported
      end else begin
         tick_count_in  = 8'd0;
         entry_index_in = idx;
         if (tune.in_window) begin
            stable_hits_in = hits_inc;
            if (hits_inc > stable_needed_ff) begin
               stable_hits_in = 8'd0;
               table_we       = 1'b1;
               store_valid_in = 1'b1;
               store_index_in = idx;
               store_value_in = tuned_pwm_ff;
               if (idx < LAST_ENTRY) begin
                  entry_index_in = idx_next;
                  tuned_pwm_in   = pwm_table_ff[idx_next[TAB_IW-1:0]];
               end else begin
                  // last entry: clear the run and stay finished
                  ramp_level_in  = 16'd0;
                  stable_hits_in = 8'd0;
                  entry_index_in = 4'd0;
                  integrator_in  = 16'd0;
                  tuned_pwm_in   = 16'd0;
                  done_in        = 1'b1;
                  finished_in    = 1'b1;
               end
            end
         end else begin
            stable_hits_in = 8'd0;
            integrator_in  = tune.integ;
            tuned_pwm_in   = tune.integ;
            limit_valid_in = 1'b1;
            limit_pwm_in   = tune.integ;
         end
      end
   end

   assign rsp_valid_in = req_xfer || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         ramp_limit_ff    <= RESET_RAMP_LIMIT;
         settle_ticks_ff  <= RESET_SETTLE_TICKS;
         stable_needed_ff <= RESET_STABLE_NEEDED;
         accept_window_ff <= RESET_ACCEPT_WINDOW;
         tune_deadband_ff <= RESET_TUNE_DEADBAND;
         output_max_ff    <= RESET_OUTPUT_MAX;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_RAMP_LIMIT:    ramp_limit_ff    <= csr_wdata;
            CSR_SETTLE_TICKS:  settle_ticks_ff  <= csr_wdata[7:0];
            CSR_STABLE_NEEDED: stable_needed_ff <= csr_wdata[7:0];
            CSR_ACCEPT_WINDOW: accept_window_ff <= csr_wdata[11:0];
            CSR_TUNE_DEADBAND: tune_deadband_ff <= csr_wdata[11:0];
            CSR_OUTPUT_MAX:    output_max_ff    <= csr_wdata;
            default: ;   // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ramp_level_ff  <= 16'd0;
         tick_count_ff  <= 8'd0;
         stable_hits_ff <= 8'd0;
         entry_index_ff <= 4'd0;
         integrator_ff  <= 16'd0;
         tuned_pwm_ff   <= 16'd0;
         done_ff        <= 1'b0;
      end else if (req_xfer) begin
         ramp_level_ff  <= ramp_level_in;
         tick_count_ff  <= tick_count_in;
         stable_hits_ff <= stable_hits_in;
         entry_index_ff <= entry_index_in;
         integrator_ff  <= integrator_in;
         tuned_pwm_ff   <= tuned_pwm_in;
         done_ff        <= done_in;
      end
   end

   // PWM table: defaults at reset, one entry written per stored calibration
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTRY_COUNT; i++) begin
            pwm_table_ff[i] <= default_pwm(4'(i));
         end
      end else if (req_xfer && table_we) begin
         pwm_table_ff[idx[TAB_IW-1:0]] <= tuned_pwm_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         motor_valid_ff <= motor_valid_in;
         motor_level_ff <= motor_level_in;
         limit_valid_ff <= limit_valid_in;
         limit_pwm_ff   <= limit_pwm_in;
         store_valid_ff <= store_valid_in;
         store_index_ff <= store_index_in;
         store_value_ff <= store_value_in;
         finished_ff    <= finished_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_motor_valid = motor_valid_ff;
   assign rsp_motor_level = motor_level_ff;
   assign rsp_limit_valid = limit_valid_ff;
   assign rsp_limit_pwm   = limit_pwm_ff;
   assign rsp_store_valid = store_valid_ff;
   assign rsp_store_index = store_index_ff;
   assign rsp_store_value = store_value_ff;
   assign rsp_finished    = finished_ff;

   // checks
   `ASSERT_IMPLIES(a_done_cleared, done_ff,
      (ramp_level_ff == 16'd0) && (entry_index_ff == 4'd0) && (integrator_ff == 16'd0),
      "finished sequencer still holds run state")
   `ASSERT_NEXT(a_done_reports, req_xfer && done_ff,
      rsp_valid_ff && finished_ff && !store_valid_ff && !limit_valid_ff,
      "transfer after finish did not report finished only")
   `ASSERT_IMPLIES(a_one_event, rsp_valid_ff,
      $onehot0({motor_valid_ff, limit_valid_ff, store_valid_ff}),
      "more than one event in one result")
   `ASSERT_ALWAYS(a_entry_range, entry_index_ff <= LAST_ENTRY,
      "entry index beyond table")

endmodule

>>> design/clcs_tune.sv
// Tuning datapath: window check and clamped integral step for one sample.
// Depends on clcs_pkg (tune_result_type).
module clcs_tune import clcs_pkg::*; (
   input  logic [11:0]     current,
   input  logic [8:0]      target,
   input  logic [15:0]     integrator,
   input  logic [11:0]     accept_window,
   input  logic [11:0]     tune_deadband,
   input  logic [15:0]     output_max,
   output tune_result_type result
);

   logic signed [12:0] err;      // current - target
   logic        [11:0] err_mag;
   logic signed [17:0] step;     // target - current, or zero inside deadband
   logic signed [17:0] acc;

   assign err     = $signed({1'b0, current}) - $signed({4'b0000, target});
   assign err_mag = err[12] ? 12'(-err) : err[11:0];

   always_comb begin
      step = (err_mag > tune_deadband) ? -18'(err) : 18'sd0;
      acc  = $signed({2'b00, integrator}) + step;
      result.in_window = (err_mag < accept_window);
      priority if (acc < 18'sd0) begin
         result.integ = 16'd0;
      end else if (acc > $signed({2'b00, output_max})) begin
         result.integ = output_max;
      end else begin
         result.integ = acc[15:0];
      end
   end

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for current_limit_calibration_sequencer.
// Depends on clcs_pkg and the design; the tick predictor is kept here and
// every result transfer is checked against it.
`timescale 1ns / 100ps

module testbench;
   import clcs_pkg::*;

   localparam int unsigned ENTRY_COUNT  = 12;
   localparam int unsigned RANDOM_ITEMS = 600;    // mixed-config phases
   localparam int unsigned FINAL_CAP    = 600;    // safety cap on the closing phase
   localparam int unsigned CYCLE_LIMIT  = 200000;

   // directed openers, one per configuration
   localparam logic [11:0] OPENING_RAMP_TUNE [12] = '{
      12'd0, 12'hFFF, 12'hAAA, 12'hFFF, 12'd0, 12'd134,
      12'd136, 12'd141, 12'd140, 12'd153, 12'd160, 12'h555};
   localparam logic [11:0] OPENING_HOLD [6] = '{
      12'd0, 12'hFFF, 12'd0, 12'h555, 12'd200, 12'hFFF};
   localparam logic [11:0] OPENING_WIDE [3] = '{12'h123, 12'hFFF, 12'd0};
   localparam logic [11:0] OPENING_CLAMP [4] = '{12'd0, 12'hFFF, 12'h7D0, 12'h12C};

   // one result transfer, in port order
   typedef struct packed {
      logic        motor_valid;
      logic [14:0] motor_level;
      logic        limit_valid;
      logic [15:0] limit_pwm;
      logic        store_valid;
      logic [3:0]  store_index;
      logic [15:0] store_value;
      logic        finished;
   } tick_result_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   logic [11:0]   req_current = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   logic          rsp_motor_valid;
   logic [14:0]   rsp_motor_level;
   logic          rsp_limit_valid;
   logic [15:0]   rsp_limit_pwm;
   logic          rsp_store_valid;
   logic [3:0]    rsp_store_index;
   logic [15:0]   rsp_store_value;
   logic          rsp_finished;
   logic          csr_we = 1'b0;
   csr_index_type csr_index = CSR_RAMP_LIMIT;
   logic [15:0]   csr_wdata = '0;

   // ticks waiting to be sent, and predicted results waiting to arrive
   logic [11:0]     pending_currents [$];
   tick_result_type expected_ticks [$];

   logic        req_fired = 1'b0;   // transfer seen on the previous rising edge
   logic        rsp_fired = 1'b0;
   int unsigned send_gap = 0;
   int unsigned recv_gap = 0;
   bit          no_idle = 1'b0;     // phase without any gaps or stalls
   int unsigned failures = 0;
   int unsigned cycle_count = 0;

   // predictor copy of the registers
   logic [15:0] cfg_ramp_top;
   logic [7:0]  cfg_settle;
   logic [7:0]  cfg_hits_needed;
   logic [11:0] cfg_window;
   logic [11:0] cfg_deadband;
   logic [15:0] cfg_pwm_max;

   // predictor copy of the sequencer state
   logic [15:0] drive_level;
   logic [7:0]  settle_count;
   logic [7:0]  hit_count;
   logic [3:0]  active_entry;
   logic [15:0] integ_acc;
   logic [15:0] tuned_level;
   logic        all_done;
   logic [15:0] cal_pwm    [ENTRY_COUNT];
   logic [8:0]  cal_target [ENTRY_COUNT];

   current_limit_calibration_sequencer #(
      .ENTRY_COUNT(ENTRY_COUNT)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_current     (req_current),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_motor_valid (rsp_motor_valid),
      .rsp_motor_level (rsp_motor_level),
      .rsp_limit_valid (rsp_limit_valid),
      .rsp_limit_pwm   (rsp_limit_pwm),
      .rsp_store_valid (rsp_store_valid),
      .rsp_store_index (rsp_store_index),
      .rsp_store_value (rsp_store_value),
      .rsp_finished    (rsp_finished),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Advance the predictor by one accepted tick and return its result.
   function automatic void calibrate_tick(input logic [11:0] sample,
                                          output tick_result_type res);
      int unsigned row;
      int          diff;
      int          mag;
      int          acc;
      res = '0;
      // once the last entry is stored nothing moves any more
      if (all_done) begin
         res.finished = 1'b1;
         return;
      end
      // ramp phase: one step per tick, settle counter held at zero
      if (drive_level < cfg_ramp_top) begin
         drive_level     = drive_level + 16'd1;
         settle_count    = '0;
         res.motor_valid = 1'b1;
         res.motor_level = drive_level[15:1];
         return;
      end
      // 8-bit wrap before the compare: a settle of 255 never evaluates
      settle_count = settle_count + 8'd1;
      if (settle_count <= cfg_settle)
         return;
      settle_count = '0;
      row = active_entry;
      if (row >= ENTRY_COUNT)
         row = ENTRY_COUNT - 1;
      active_entry = 4'(row);
      diff = int'(sample) - int'(cal_target[row]);
      mag  = (diff < 0) ? -diff : diff;
      if (mag < int'(cfg_window)) begin
         hit_count = hit_count + 8'd1;
         if (hit_count > cfg_hits_needed) begin
            hit_count       = '0;
            cal_pwm[row]    = tuned_level;
            res.store_valid = 1'b1;
            res.store_index = 4'(row);
            res.store_value = tuned_level;
            if (row < ENTRY_COUNT - 1) begin
               active_entry = 4'(row + 1);
               tuned_level  = cal_pwm[row + 1];
            end else begin
               // last entry: run state clears, stored table survives
               drive_level  = '0;
               settle_count = '0;
               hit_count    = '0;
               active_entry = '0;
               integ_acc    = '0;
               tuned_level  = '0;
               all_done     = 1'b1;
               res.finished = 1'b1;
            end
         end
      end else begin
         // integral step with deadband, clamped to 0..max
         hit_count = '0;
         diff = int'(cal_target[row]) - int'(sample);
         mag  = (diff < 0) ? -diff : diff;
         acc  = int'(integ_acc);
         if (mag > int'(cfg_deadband))
            acc = acc + diff;
         if (acc < 0)
            acc = 0;
         if (acc > int'(cfg_pwm_max))
            acc = int'(cfg_pwm_max);
         integ_acc       = 16'(acc);
         tuned_level     = integ_acc;
         res.limit_valid = 1'b1;
         res.limit_pwm   = tuned_level;
      end
   endfunction

   function automatic int unsigned check_field(input string name, input int unsigned want,
                                               input int unsigned got);
      if (want == got)
         return 0;
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1;
   endfunction

   // Current sample around the active entry's target. hit_pct is the share
   // aimed inside the window; at zero the sample always misses it.
   function automatic logic [11:0] pick_current(input int unsigned hit_pct);
      int center;
      int offset;
      int value;
      center = int'(cal_target[active_entry]);
      if (hit_pct != 0 && $urandom_range(99) < 10)
         return 12'($urandom_range(4095));
      if (cfg_window != 0 && $urandom_range(99) < hit_pct)
         offset = $urandom_range(int'(cfg_window) - 1);
      else
         offset = int'(cfg_window) + $urandom_range(40);
      value = $urandom_range(1) ? center + offset : center - offset;
      if (value > 4095)
         value = center - offset;
      if (value < 0)
         value = center + offset;
      if (value > 4095)
         value = 4095;
      return 12'(value);
   endfunction

   // Register write on the plain write port; the predictor copy follows.
   task automatic write_csr(input csr_index_type idx, input logic [15:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_RAMP_LIMIT:    cfg_ramp_top    = data;
         CSR_SETTLE_TICKS:  cfg_settle      = data[7:0];
         CSR_STABLE_NEEDED: cfg_hits_needed = data[7:0];
         CSR_ACCEPT_WINDOW: cfg_window      = data[11:0];
         CSR_TUNE_DEADBAND: cfg_deadband    = data[11:0];
         CSR_OUTPUT_MAX:    cfg_pwm_max     = data;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic configure(input logic [15:0] ramp, input logic [15:0] settle,
                            input logic [15:0] hits, input logic [15:0] win,
                            input logic [15:0] band, input logic [15:0] pmax);
      write_csr(CSR_RAMP_LIMIT, ramp);
      write_csr(CSR_SETTLE_TICKS, settle);
      write_csr(CSR_STABLE_NEEDED, hits);
      write_csr(CSR_ACCEPT_WINDOW, win);
      write_csr(CSR_TUNE_DEADBAND, band);
      write_csr(CSR_OUTPUT_MAX, pmax);
   endtask

   // Waits until every queued tick has been sent and every predicted result received.
   task automatic wait_idle();
      while (pending_currents.size() != 0 || req_valid || expected_ticks.size() != 0)
         @(posedge clock);
   endtask

   task automatic queue_random(input int unsigned count);
      repeat (count) pending_currents.push_back(12'($urandom_range(4095)));
   endtask

   // Stimulus: directed openers, long-count corner phases, random phases with
   // mostly well-formed calibration traffic, then a closing run to finished.
   initial begin : stimulus
      int unsigned roll;
      int unsigned ramp;
      int unsigned settle;
      int unsigned hits;
      int unsigned win;
      int unsigned band;
      int unsigned pmax;
      int unsigned len;
      int unsigned sent;
      int          center;
      bit          may_hit;

      cfg_ramp_top    = RESET_RAMP_LIMIT;
      cfg_settle      = RESET_SETTLE_TICKS;
      cfg_hits_needed = RESET_STABLE_NEEDED;
      cfg_window      = RESET_ACCEPT_WINDOW;
      cfg_deadband    = RESET_TUNE_DEADBAND;
      cfg_pwm_max     = RESET_OUTPUT_MAX;
      drive_level     = '0;
      settle_count    = '0;
      hit_count       = '0;
      active_entry    = '0;
      integ_acc       = '0;
      tuned_level     = '0;
      all_done        = 1'b0;
      for (int r = 0; r < ENTRY_COUNT; r++) begin
         cal_pwm[r]    = default_pwm(4'(r));
         cal_target[r] = default_target(4'(r));
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // short ramp, tight window: ramp, clamp at zero, accepts, deadband hold
      configure(16'd3, 16'd0, 16'd1, 16'd2, 16'd3, 16'd2400);
      foreach (OPENING_RAMP_TUNE[i]) pending_currents.push_back(OPENING_RAMP_TUNE[i]);
      wait_idle();
      // no ramp, every third tick evaluated, nothing in window, full deadband
      configure(16'd0, 16'd2, 16'd0, 16'd0, 16'd4095, 16'd100);
      foreach (OPENING_HOLD[i]) pending_currents.push_back(OPENING_HOLD[i]);
      wait_idle();
      // widest window: every tick accepts the entry at once
      configure(16'd0, 16'd0, 16'd0, 16'd4095, 16'd0, 16'd0);
      foreach (OPENING_WIDE[i]) pending_currents.push_back(OPENING_WIDE[i]);
      wait_idle();
      // output max of zero pins the integrator
      configure(16'd0, 16'd0, 16'd255, 16'd1, 16'd0, 16'd0);
      foreach (OPENING_CLAMP[i]) pending_currents.push_back(OPENING_CLAMP[i]);
      wait_idle();

      // highest ramp limit: a stretch of pure ramp ticks
      configure(16'hFFFF, 16'd0, 16'd4, 16'd30, 16'd3, 16'd2400);
      queue_random(30);
      wait_idle();
      // settle of 255 wraps the tick counter and never evaluates
      configure(16'd0, 16'd255, 16'd0, 16'd4095, 16'd5, 16'd2400);
      no_idle = 1'b1;
      queue_random(260);
      wait_idle();
      // stable count of 255 wraps the hit counter and never accepts
      configure(16'd0, 16'd0, 16'd255, 16'd4095, 16'($urandom_range(4095)),
                16'($urandom_range(65535)));
      no_idle = 1'b0;
      queue_random(260);
      wait_idle();

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         roll = $urandom_range(99);
         ramp = (roll < 10) ? 0 : int'(drive_level) + $urandom_range(8);
         roll = $urandom_range(99);
         settle = (roll < 10) ? 255 : (roll < 20) ? $urandom_range(255) : $urandom_range(3);
         roll = $urandom_range(99);
         hits = (roll < 10) ? 255 : (roll < 20) ? $urandom_range(255) : $urandom_range(4);
         roll = $urandom_range(99);
         if (roll < 5)
            win = 0;
         else if (roll < 10)
            win = (active_entry < 9) ? 4095 : 1000;
         else if (roll < 20)
            win = $urandom_range(4095);
         else
            win = $urandom_range(40, 1);
         if (active_entry >= 9 && win > 1000)
            win = 1000;
         roll = $urandom_range(99);
         band = (roll < 10) ? 4095 : (roll < 20) ? $urandom_range(4095) : $urandom_range(40);
         roll = $urandom_range(99);
         pmax = (roll < 10) ? 0 : (roll < 20) ? 65535 :
                (roll < 35) ? $urandom_range(65535) : $urandom_range(3000, 100);
         configure(16'(ramp), 16'(settle), 16'(hits), 16'(win), 16'(band), 16'(pmax));
         no_idle = ($urandom_range(3) == 0);
         len = $urandom_range(80, 20);
         for (int k = 0; k < len; k++) begin
            // keep the last entry out of reach until the closing phase;
            // the view of the predictor trails the sender by one tick
            may_hit = (active_entry < 10);
            center  = int'(cal_target[active_entry]);
            if (!may_hit && center + int'(cfg_window) > 4095 && center < int'(cfg_window))
               break;
            while (pending_currents.size() != 0)
               @(posedge clock);
            pending_currents.push_back(pick_current(may_hit ? 65 : 0));
            sent++;
         end
         wait_idle();
      end

      // closing phase: well-formed traffic until every entry is stored
      configure(16'd0, 16'($urandom_range(1)), 16'($urandom_range(2)),
                16'($urandom_range(60, 20)), 16'($urandom_range(10)),
                16'($urandom_range(3000, 500)));
      no_idle = 1'b0;
      sent = 0;
      while (!all_done && sent < FINAL_CAP) begin
         while (pending_currents.size() != 0)
            @(posedge clock);
         pending_currents.push_back(pick_current(90));
         sent++;
      end
      // finished is sticky: later ticks must do nothing else
      queue_random(20);

      wait_idle();
      repeat (10) @(posedge clock);
      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Request driver: holds each transfer until accepted, then waits its gap.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else if (!req_valid || req_fired) begin
         if (send_gap != 0) begin
            req_valid <= 1'b0;
            send_gap  <= send_gap - 1;
         end else if (pending_currents.size() != 0) begin
            req_valid   <= 1'b1;
            req_current <= pending_currents.pop_front();
            send_gap    <= no_idle ? 0 : $urandom_range(9);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result receiver: after each transfer, stalls for a drawn number of cycles.
   always @(negedge clock) begin : receiver
      int unsigned stall;
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_gap  <= 0;
      end else begin
         stall = recv_gap;
         if (rsp_fired)
            stall = no_idle ? 0 : $urandom_range(9);
         rsp_ready <= (stall == 0);
         recv_gap  <= (stall == 0) ? 0 : stall - 1;
      end
   end

   // Monitor: checks each result transfer against the oldest prediction,
   // then predicts the tick accepted on this edge.
   always @(posedge clock) begin : monitor
      tick_result_type seen;
      tick_result_type want;
      req_fired <= req_valid && req_ready;
      rsp_fired <= rsp_valid && rsp_ready;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            seen = {rsp_motor_valid, rsp_motor_level, rsp_limit_valid, rsp_limit_pwm,
                    rsp_store_valid, rsp_store_index, rsp_store_value, rsp_finished};
            if (expected_ticks.size() == 0) begin
               $error("result transfer with no tick outstanding");
               failures++;
            end else begin
               want = expected_ticks.pop_front();
               failures += check_field("motor_valid", want.motor_valid, seen.motor_valid);
               failures += check_field("motor_level", want.motor_level, seen.motor_level);
               failures += check_field("limit_valid", want.limit_valid, seen.limit_valid);
               failures += check_field("limit_pwm", want.limit_pwm, seen.limit_pwm);
               failures += check_field("store_valid", want.store_valid, seen.store_valid);
               failures += check_field("store_index", want.store_index, seen.store_index);
               failures += check_field("store_value", want.store_value, seen.store_value);
               failures += check_field("finished", want.finished, seen.finished);
            end
         end
         if (req_valid && req_ready) begin
            calibrate_tick(req_current, want);
            expected_ticks.push_back(want);
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

endmodule
